// ===== hw/rtl/vbs_pkg.sv =====
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared types and constants of the ball step unit.
// ----------------------------------------------------------------------------
`default_nettype none
package vbs_pkg;
	localparam int unsigned VW  = 32;
	localparam int unsigned DTW = 16;
	localparam int unsigned CW  = 24;

	localparam logic [2:0] REG_GRAVITY_Y   = 3'd0;
	localparam logic [2:0] REG_DRAG_COEF   = 3'd1;
	localparam logic [2:0] REG_INV_MASS    = 3'd2;
	localparam logic [2:0] REG_WALL_LEFT   = 3'd3;
	localparam logic [2:0] REG_WALL_RIGHT  = 3'd4;
	localparam logic [2:0] REG_WALL_TOP    = 3'd5;
	localparam logic [2:0] REG_WALL_BOTTOM = 3'd6;

	localparam logic signed [VW-1:0] RST_GRAVITY = 32'sd6429082;
	localparam logic [CW-1:0]        RST_DRAG    = 24'd6554;
	localparam logic [CW-1:0]        RST_INVM    = 24'd65536;
	localparam logic signed [VW-1:0] RST_WL      = 32'sd4194304;
	localparam logic signed [VW-1:0] RST_WR      = 32'sd121634816;
	localparam logic signed [VW-1:0] RST_WT      = 32'sd4194304;
	localparam logic signed [VW-1:0] RST_WB      = 32'sd66584576;
	localparam logic signed [VW-1:0] RST_PX      = 32'sd62914560;
	localparam logic signed [VW-1:0] RST_PY      = 32'sd35389440;

	localparam logic signed [VW-1:0] SMAX = 32'sh7fffffff;
	localparam logic signed [VW-1:0] SMIN = 32'sh80000000;

	typedef struct packed {
		logic                 start;
		logic signed [33:0]   a;
		logic        [33:0]   b;
	} vbs_mul_req_t;

	function automatic logic signed [VW-1:0] sat32(input logic signed [67:0] v);
		if (v > 68'sh7fffffff) return SMAX;
		if (v < -68'sh80000000) return SMIN;
		return v[VW-1:0];
	endfunction

	function automatic logic signed [67:0] rshift(input logic signed [67:0] v,
		input int unsigned s);
		logic signed [67:0] t;
		t = v + (68'sd1 <<< (s - 1));
		return t >>> s;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/vbs_mul.sv =====
// ----------------------------------------------------------------------------
// vbs_mul
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module vbs_mul import vbs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vbs_mul_req_t        req,
	output logic                     done,
	output logic signed [67:0]       prod
);
	logic        [5:0]        cnt_q;
	logic                     busy_q;
	logic        [33:0]       b_q;
	logic signed [67:0]       a_q;
	logic signed [67:0]       acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= 68'(req.a);
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

// ===== hw/rtl/verlet_ball_step_with_bounce_unit.sv =====
// ----------------------------------------------------------------------------
// verlet_ball_step_with_bounce_unit
// One ball advanced by velocity Verlet per tick, clamped against four walls.
// ----------------------------------------------------------------------------
// Input channel: step_length with in_valid/in_stall; one transfer per tick.
// Output channel: new position, velocity and hit flags with out_valid and
// out_stall; one transfer per accepted tick.
// The block works on one tick at a time. Each tick runs eleven products
// through one shared bit-serial multiplier; the next input is taken once
// the result sits in the output register. While out_stall is high the result
// holds; one more tick may be taken and computed, after which in_stall stays
// high until the held result leaves. Reset restores registers to their
// defaults and the ball to screen center at rest. Configuration writes take
// effect at once. The user is to write configuration only while idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module verlet_ball_step_with_bounce_unit import vbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [31:0]           cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [DTW-1:0]        step_length,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [VW-1:0]       out_pos_x,
	output logic signed [VW-1:0]       out_pos_y,
	output logic signed [VW-1:0]       out_vel_x,
	output logic signed [VW-1:0]       out_vel_y,
	output logic                       hit_side,
	output logic                       hit_floor_or_top
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_WAIT = 4'd2;
	localparam logic [3:0] ST_FIN  = 4'd3;
	localparam logic [3:0] ST_OUT  = 4'd4;

	logic [3:0] state_q;
	logic [3:0] op_q;

	logic signed [VW-1:0] grav_q, wl_q, wr_q, wt_q, wb_q;
	logic        [CW-1:0] drag_q, invm_q;
	logic signed [VW-1:0] px_q, py_q, vx_q, vy_q, ax_q, ay_q;
	logic        [DTW-1:0] dt_q;
	logic        [DTW:0]   hdt2_q;
	logic signed [67:0]   pnx_q, pny_q;
	logic signed [VW-1:0] dfx_q, dfy_q, nax_q, nay_q;
	logic signed [67:0]   nvx_q, nvy_q;

	vbs_mul_req_t      mreq;
	logic              mdone;
	logic signed [67:0] mprod;

	vbs_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .prod(mprod));

	always_comb begin
		mreq.start = (state_q == ST_MUL);
		mreq.a = '0;
		mreq.b = '0;
		case (op_q)
			4'd0: begin mreq.a = 34'(signed'({1'b0, dt_q})); mreq.b = 34'(dt_q); end
			4'd1: begin mreq.a = 34'(vx_q); mreq.b = 34'(dt_q); end
			4'd2: begin mreq.a = 34'(ax_q); mreq.b = 34'(hdt2_q); end
			4'd3: begin mreq.a = 34'(vy_q); mreq.b = 34'(dt_q); end
			4'd4: begin mreq.a = 34'(ay_q); mreq.b = 34'(hdt2_q); end
			4'd5: begin mreq.a = 34'(vx_q); mreq.b = 34'(drag_q); end
			4'd6: begin mreq.a = 34'(vy_q); mreq.b = 34'(drag_q); end
			4'd7: begin mreq.a = 34'(dfx_q); mreq.b = 34'(invm_q); end
			4'd8: begin mreq.a = 34'(dfy_q); mreq.b = 34'(invm_q); end
			4'd9: begin mreq.a = 34'(nax_q) + 34'(ax_q); mreq.b = 34'(dt_q); end
			4'd10: begin mreq.a = 34'(nay_q) + 34'(ay_q); mreq.b = 34'(dt_q); end
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	logic signed [VW-1:0] fpx, fpy, fvx, fvy;
	logic                 fhs, fhv;

	always_comb begin
		fpx = sat32(pnx_q);
		fvx = sat32(nvx_q);
		fhs = 1'b0;
		if (fpx <= wl_q) begin fpx = wl_q; fvx = sat32(-68'(fvx)); fhs = 1'b1; end
		if (fpx >= wr_q) begin fpx = wr_q; fvx = sat32(-68'(fvx)); fhs = 1'b1; end
		fpy = sat32(pny_q);
		fvy = sat32(nvy_q);
		fhv = 1'b0;
		if (fpy <= wt_q) begin fpy = wt_q; fvy = sat32(-68'(fvy)); fhv = 1'b1; end
		if (fpy >= wb_q) begin fpy = wb_q; fvy = sat32(-68'(fvy)); fhv = 1'b1; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= '0;
			out_valid <= 1'b0;
			grav_q <= RST_GRAVITY; drag_q <= RST_DRAG; invm_q <= RST_INVM;
			wl_q <= RST_WL; wr_q <= RST_WR; wt_q <= RST_WT; wb_q <= RST_WB;
			px_q <= RST_PX; py_q <= RST_PY;
			vx_q <= '0; vy_q <= '0; ax_q <= '0; ay_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRAVITY_Y:   grav_q <= cfg_data;
					REG_DRAG_COEF:   drag_q <= cfg_data[CW-1:0];
					REG_INV_MASS:    invm_q <= cfg_data[CW-1:0];
					REG_WALL_LEFT:   wl_q <= cfg_data;
					REG_WALL_RIGHT:  wr_q <= cfg_data;
					REG_WALL_TOP:    wt_q <= cfg_data;
					REG_WALL_BOTTOM: wb_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					op_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_WAIT;
				ST_WAIT: if (mdone) begin
					op_q <= op_q + 4'd1;
					state_q <= (op_q == 4'd10) ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					px_q <= fpx; py_q <= fpy; vx_q <= fvx; vy_q <= fvy;
					ax_q <= nax_q; ay_q <= nay_q;
					state_q <= ST_OUT;
				end
				ST_OUT: if (!out_valid || !out_stall) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) dt_q <= step_length;
		if (state_q == ST_WAIT && mdone) begin
			case (op_q)
				4'd0: hdt2_q <= (DTW+1)'(rshift(mprod, 17));
				4'd1: pnx_q <= 68'(px_q) + rshift(mprod, 16);
				4'd2: pnx_q <= pnx_q + rshift(mprod, 16);
				4'd3: pny_q <= 68'(py_q) + rshift(mprod, 16);
				4'd4: pny_q <= pny_q + rshift(mprod, 16);
				4'd5: dfx_q <= sat32(rshift(mprod, 16));
				4'd6: dfy_q <= sat32(rshift(mprod, 16));
				4'd7: nax_q <= sat32(-68'(sat32(rshift(mprod, 16))));
				4'd8: nay_q <= sat32(68'(grav_q) - 68'(sat32(rshift(mprod, 16))));
				4'd9: nvx_q <= 68'(vx_q) + rshift(mprod, 17);
				4'd10: nvy_q <= 68'(vy_q) + rshift(mprod, 17);
				default: ;
			endcase
		end
		if (state_q == ST_OUT && (!out_valid || !out_stall)) begin
			out_pos_x <= px_q; out_pos_y <= py_q;
			out_vel_x <= vx_q; out_vel_y <= vy_q;
			hit_side <= fhs; hit_floor_or_top <= fhv;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/vbs_checker.sv =====
// ----------------------------------------------------------------------------
// vbs_checker
// Port-level checks of the ball step unit.
// ----------------------------------------------------------------------------
`default_nettype none
module vbs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [31:0] out_pos_x
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_pos_x)) else $error("held");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("busy");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid || out_stall || $past(out_valid))
		else $error("spurious");
endmodule

bind verlet_ball_step_with_bounce_unit vbs_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .out_pos_x(out_pos_x));
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Ball step unit testbench
// Drives time ticks into the velocity Verlet ball unit, predicts each new
// position, velocity and wall hit in fixed point, and compares every output
// transfer with its prediction. Runs through several register settings, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb import vbs_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               hs;
		logic               hv;
	} ball_t;

	typedef struct {
		logic [15:0] dt;
		logic        known;
		ball_t       res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] step_length = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
	logic hit_side, hit_floor_or_top;

	verlet_ball_step_with_bounce_unit DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#200ms;
		$display("Mismatches found");
		$finish;
	end

	// predictor state
	logic signed [31:0] grav, wl, wr, wt, wb;
	logic [23:0] drag, invm;
	logic signed [31:0] px, py, vx, vy, ax, ay;

	ball_t ball_q[$];
	int errors = 0;
	ball_t known_q[$];
	logic known_flag_q[$];
	bit in_idle_on = 1'b1, out_idle_on = 1'b1;
	bit hold_out = 1'b0;

	function automatic logic signed [67:0] rnd(logic signed [67:0] v, int s);
		logic signed [67:0] t;
		t = v + (68'sd1 <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic logic signed [31:0] clip(logic signed [67:0] v);
		if (v > 68'sd2147483647) return 32'sh7fffffff;
		if (v < -68'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic void advance_axis(inout logic signed [31:0] p, v, a,
		input logic signed [31:0] g, input logic [15:0] dt, input logic [16:0] h);
		logic signed [67:0] np, nv;
		logic signed [31:0] df, da, na;
		np = 68'(p) + rnd(68'(v) * $signed({52'd0, dt}), 16)
			+ rnd(68'(a) * $signed({51'd0, h}), 16);
		df = clip(rnd($signed({44'd0, drag}) * 68'(v), 16));
		da = clip(rnd($signed({44'd0, invm}) * 68'(df), 16));
		na = clip(68'(g) - 68'(da));
		nv = 68'(v) + rnd((68'(na) + 68'(a)) * $signed({52'd0, dt}), 17);
		p = clip(np);
		v = clip(nv);
		a = na;
	endfunction

	function automatic logic clamp_axis(inout logic signed [31:0] p, v,
		input logic signed [31:0] lo, hi);
		logic hit;
		hit = 1'b0;
		if (p <= lo) begin
			p = lo;
			v = clip(-68'(v));
			hit = 1'b1;
		end
		if (p >= hi) begin
			p = hi;
			v = clip(-68'(v));
			hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic ball_t tick_ball(logic [15:0] dt);
		ball_t r;
		logic [16:0] h;
		h = 17'(rnd(68'(dt) * 68'(dt), 17));
		advance_axis(px, vx, ax, 32'sd0, dt, h);
		advance_axis(py, vy, ay, grav, dt, h);
		r.hs = clamp_axis(px, vx, wl, wr);
		r.hv = clamp_axis(py, vy, wt, wb);
		r.px = px;
		r.py = py;
		r.vx = vx;
		r.vy = vy;
		return r;
	endfunction

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_GRAVITY_Y:   grav = val;
			REG_DRAG_COEF:   drag = val[23:0];
			REG_INV_MASS:    invm = val[23:0];
			REG_WALL_LEFT:   wl = val;
			REG_WALL_RIGHT:  wr = val;
			REG_WALL_TOP:    wt = val;
			REG_WALL_BOTTOM: wb = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(logic [15:0] dt, logic known, ball_t typed);
		ball_t r;
		if (in_idle_on && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 33);
		end
		r = tick_ball(dt);
		ball_q.insert(ball_q.size(), r);
		known_flag_q.insert(known_flag_q.size(), known);
		known_q.insert(known_q.size(), typed);
		in_valid <= 1'b1;
		step_length <= dt;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (ball_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (500) @(posedge clk);
	endtask

	// output side
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				ball_t got, want;
				got = '{out_pos_x, out_pos_y, out_vel_x, out_vel_y,
					hit_side, hit_floor_or_top};
				if (ball_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %p", got);
				end else begin
					want = ball_q.pop_front();
					if (known_flag_q.pop_front() && known_q[0] != want) begin
						errors++;
						if (errors <= 10) $display("typed row %p vs predicted %p",
							known_q[0], want);
					end
					void'(known_q.pop_front());
					if (got !== want) begin
						errors++;
						if (errors <= 10) $display("expected %p got %p", want, got);
					end
				end
			end
			out_stall <= hold_out || (out_idle_on && $urandom_range(99) < 33);
		end
	end

	dir_row_t rows[$];
	int sweep;

	initial begin
		grav = RST_GRAVITY; drag = RST_DRAG; invm = RST_INVM;
		wl = RST_WL; wr = RST_WR; wt = RST_WT; wb = RST_WB;
		px = RST_PX; py = RST_PY; vx = 0; vy = 0; ax = 0; ay = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero step right after reset leaves the ball at center at rest
		rows.insert(rows.size(),
			'{16'd0, 1'b1, '{RST_PX, RST_PY, 32'sd0, 32'sd0, 1'b0, 1'b0}});
		rows.insert(rows.size(), '{16'hffff, 1'b0, '0});
		rows.insert(rows.size(), '{16'd1, 1'b0, '0});
		rows.insert(rows.size(), '{16'h8000, 1'b0, '0});
		rows.insert(rows.size(), '{16'h5555, 1'b0, '0});
		rows.insert(rows.size(), '{16'haaaa, 1'b0, '0});
		for (int i = 0; i < 8; i++) rows.insert(rows.size(), '{16'hffff, 1'b0, '0});
		rows.insert(rows.size(), '{16'd0, 1'b0, '0});
		foreach (rows[i]) send_tick(rows[i].dt, rows[i].known, rows[i].res);
		drain();

		// extremes: huge gravity and drag drive saturation and floor hits
		cfg_write(REG_GRAVITY_Y, 32'h7fffffff);
		cfg_write(REG_DRAG_COEF, 32'hffffff);
		cfg_write(REG_INV_MASS, 32'hffffff);
		for (int i = 0; i < 6; i++) send_tick(16'hffff, 1'b0, '0);
		drain();
		cfg_write(REG_GRAVITY_Y, 32'h80000000);
		cfg_write(REG_DRAG_COEF, 32'd0);
		cfg_write(REG_INV_MASS, 32'd0);
		for (int i = 0; i < 6; i++) send_tick(16'hffff, 1'b0, '0);
		drain();
		// crossed walls: both tests fire, position lands on high wall
		cfg_write(REG_WALL_LEFT, 32'h7fffffff);
		cfg_write(REG_WALL_RIGHT, 32'h80000000);
		cfg_write(REG_WALL_TOP, 32'h7fffffff);
		cfg_write(REG_WALL_BOTTOM, 32'h80000000);
		cfg_write(3'd7, 32'hffffffff);
		for (int i = 0; i < 4; i++) send_tick(16'($urandom), 1'b0, '0);
		drain();

		for (sweep = 0; sweep < 5; sweep++) begin
			int lo, hi;
			lo = $urandom_range(200, 20) << 16;
			hi = lo + ($urandom_range(1500, 50) << 16);
			cfg_write(REG_GRAVITY_Y, sweep == 4 ? $urandom : $urandom_range(20000000));
			cfg_write(REG_DRAG_COEF, sweep == 3 ? 32'hffffff : $urandom_range(200000));
			cfg_write(REG_INV_MASS, sweep == 3 ? 32'hffffff : $urandom_range(300000));
			cfg_write(REG_WALL_LEFT, lo);
			cfg_write(REG_WALL_RIGHT, hi);
			cfg_write(REG_WALL_TOP, lo);
			cfg_write(REG_WALL_BOTTOM, sweep == 4 ? $urandom : hi);
			in_idle_on = (sweep != 1);
			out_idle_on = (sweep != 1);
			if (sweep == 2) fork
				begin
					hold_out = 1'b1;
					repeat (3000) @(posedge clk);
					hold_out = 1'b0;
				end
			join_none
			for (int i = 0; i < 245; i++) begin
				logic [15:0] dt;
				case ($urandom_range(3))
					0: dt = 16'($urandom);
					1: dt = 16'($urandom_range(2000));
					2: dt = 16'hffff - 16'($urandom_range(255));
					default: dt = 16'($urandom_range(1200, 900));
				endcase
				send_tick(dt, 1'b0, '0);
			end
			drain();
		end

		if (errors == 0 && ball_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/vbs_pkg.sv
hw/rtl/vbs_mul.sv
hw/rtl/verlet_ball_step_with_bounce_unit.sv
hw/rtl/vbs_checker.sv
tb/tb.sv
